[rtl/core/tsae_pkg.sv]
// ----------------------------------------------------------------------------
// tsae_pkg
// Shared types, codes and defaults of the tour swap annealing engine.
// ----------------------------------------------------------------------------
package tsae_pkg;

	localparam int CITIES_DEF     = 10;
	localparam int POPULATION_DEF = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TEMP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_PCT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACC_RATIO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_LIMIT  = 3'd4;

	localparam logic [15:0] START_TEMP_RST = 16'd10000;
	localparam logic [15:0] STOP_TEMP_RST  = 16'd1000;
	localparam logic [6:0]  COOL_PCT_RST   = 7'd90;
	localparam logic [15:0] ACC_RATIO_RST  = 16'd45735;
	localparam logic [4:0]  GEN_LIMIT_RST  = 5'd10;
	localparam logic [4:0]  GEN_RST        = 5'd1;
	localparam logic [4:0]  GEN_MAX        = 5'd31;

	// floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for all x < 2^23
	localparam logic [23:0] RECIP_100   = 24'd10737419;
	localparam int          RECIP_SHIFT = 30;

	localparam logic [2:0] OP_LOAD_DIST = 3'd0;
	localparam logic [2:0] OP_LOAD_TOUR = 3'd1;
	localparam logic [2:0] OP_EVAL      = 3'd2;
	localparam logic [2:0] OP_PROPOSE   = 3'd3;
	localparam logic [2:0] OP_END_GEN   = 3'd4;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_ACCEPTED = 3'd1;
	localparam logic [2:0] ST_REJECTED = 3'd2;
	localparam logic [2:0] ST_INVALID  = 3'd3;
	localparam logic [2:0] ST_FINISHED = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  member;
		logic [3:0]  index_a;
		logic [3:0]  index_b;
		logic [3:0]  city;
		logic [15:0] distance;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [19:0] tour_length;
		logic [15:0] current_temperature;
		logic [4:0]  generation;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_TRD, S_TCAP, S_DRD, S_DACC, S_MUL, S_DECIDE,
		S_WRA, S_WRB, S_GMUL, S_GDIV, S_GUPD, S_OUT
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       dist_wr;
		logic       tour_load_wr;
		logic       tour_start;
		logic       tour_rd;
		logic       tour_cap;
		logic       dist_rd;
		logic       dist_acc;
		logic       mul;
		logic       len_wr;
		logic       wr_a;
		logic       wr_b;
		logic       gen_mul;
		logic       gen_div;
		logic       gen_upd;
		logic       set_fin;
		logic       set_st;
		logic [2:0] st;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       dist_ok;
		logic       tour_ok;
		logic       slot_ok;
		logic       swap_ok;
		logic       running;
		logic       cnt_last;
		logic       accept;
		logic       gen_finish;
	} sts_t;

endpackage

[rtl/core/tsae_channels.sv]
// ----------------------------------------------------------------------------
// tsae channels
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------
interface tsae_req_if;
	logic valid;
	logic ready;
	tsae_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tsae_rsp_if;
	logic valid;
	logic ready;
	tsae_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tsae_cfg_if;
	logic valid;
	logic ready;
	logic [tsae_pkg::CFG_IDX_W-1:0] index;
	logic [tsae_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/tsae_ctrl.sv]
// ----------------------------------------------------------------------------
// tsae_ctrl
// Sequencer: dispatch, tour walk, decision, swap writes, cooling and reply.
// ----------------------------------------------------------------------------
module tsae_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  tsae_pkg::sts_t sts,
	output tsae_pkg::cmd_t cmd
);
	import tsae_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_EVAL:    state_d = sts.slot_ok ? S_TRD : S_OUT;
					OP_PROPOSE: state_d = (sts.running && sts.swap_ok) ? S_TRD : S_OUT;
					OP_END_GEN: state_d = sts.running ? S_GMUL : S_OUT;
					default:    state_d = S_OUT;
				endcase
			end
			S_TRD:    state_d = S_TCAP;
			S_TCAP:   state_d = sts.cnt_last ? S_DRD : S_TRD;
			S_DRD:    state_d = S_DACC;
			S_DACC:   state_d = sts.cnt_last ? S_MUL : S_DRD;
			S_MUL:    state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = (sts.op == OP_PROPOSE && sts.accept) ? S_WRA : S_OUT;
			end
			S_WRA:    state_d = S_WRB;
			S_WRB:    state_d = S_OUT;
			S_GMUL:   state_d = S_GDIV;
			S_GDIV:   state_d = S_GUPD;
			S_GUPD:   state_d = S_OUT;
			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.latch = req_valid;
			S_DISPATCH: begin
				cmd.set_st     = 1'b1;
				cmd.st         = ST_DONE;
				cmd.tour_start = 1'b1;
				case (sts.op)
					OP_LOAD_DIST: cmd.dist_wr = sts.dist_ok;
					OP_LOAD_TOUR: cmd.tour_load_wr = sts.tour_ok;
					OP_PROPOSE: begin
						if (!sts.running) begin
							cmd.set_fin = 1'b1;
							cmd.st      = ST_FINISHED;
						end else if (!sts.swap_ok) begin
							cmd.st = ST_INVALID;
						end
					end
					OP_END_GEN: begin
						if (!sts.running) begin
							cmd.set_fin = 1'b1;
							cmd.st      = ST_FINISHED;
						end
					end
					default: ;
				endcase
			end
			S_TRD:  cmd.tour_rd = 1'b1;
			S_TCAP: cmd.tour_cap = 1'b1;
			S_DRD:  cmd.dist_rd = 1'b1;
			S_DACC: cmd.dist_acc = 1'b1;
			S_MUL:  cmd.mul = 1'b1;
			S_DECIDE: begin
				if (sts.op == OP_PROPOSE) begin
					cmd.set_st = 1'b1;
					cmd.st     = sts.accept ? ST_ACCEPTED : ST_REJECTED;
					cmd.len_wr = sts.accept;
				end else begin
					cmd.len_wr = 1'b1;
				end
			end
			S_WRA:  cmd.wr_a = 1'b1;
			S_WRB:  cmd.wr_b = 1'b1;
			S_GMUL: cmd.gen_mul = 1'b1;
			S_GDIV: cmd.gen_div = 1'b1;
			S_GUPD: begin
				cmd.gen_upd = 1'b1;
				if (sts.gen_finish) begin
					cmd.set_fin = 1'b1;
					cmd.set_st  = 1'b1;
					cmd.st      = ST_FINISHED;
				end
			end
			S_OUT:  cmd.out_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

endmodule

[rtl/core/tsae_datapath.sv]
// ----------------------------------------------------------------------------
// tsae_datapath
// Distance and tour memories, tour lengths, annealing state and arithmetic.
// ----------------------------------------------------------------------------
module tsae_datapath #(
	parameter int CITIES     = tsae_pkg::CITIES_DEF,
	parameter int POPULATION = tsae_pkg::POPULATION_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsae_pkg::req_t                   req_data,
	input  logic                             cfg_we,
	input  logic [tsae_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsae_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  tsae_pkg::cmd_t                   cmd,
	output tsae_pkg::sts_t                   sts,
	output tsae_pkg::rsp_t                   rsp_data
);
	import tsae_pkg::*;

	localparam int DEPTH_D = CITIES * CITIES;
	localparam int DEPTH_T = POPULATION * CITIES;
	localparam int DAW     = $clog2(DEPTH_D);
	localparam int TAW     = (DEPTH_T > 1) ? $clog2(DEPTH_T) : 1;
	localparam int CW      = $clog2(CITIES);
	localparam int LW      = (POPULATION > 1) ? $clog2(POPULATION) : 1;

	// configuration and annealing state; the start temperature only feeds temp_q
	logic [15:0] stop_q, ratio_q, temp_q;
	logic [6:0]  cool_q;
	logic [4:0]  limit_q, gen_q;
	logic        fin_q;

	req_t        item_q;
	logic [2:0]  status_q;
	rsp_t        out_q;

	logic [15:0] dist_mem [DEPTH_D];
	logic [3:0]  tour_mem [DEPTH_T];
	logic [19:0] len_q [POPULATION];

	logic [3:0]  tour_q [CITIES];
	logic [CW-1:0] cnt_q;
	logic [19:0] sum_q;
	logic        leg_ok_q;
	logic [15:0] dist_rd_q;
	logic [3:0]  tour_rd_q;
	logic [3:0]  ca_q, cb_q;
	logic [31:0] prod_q;
	logic [22:0] gprod_q;
	logic [16:0] quot_q;

	logic          slot_ok, a_ok, b_ok;
	logic [LW-1:0] mi;
	logic [3:0]    sa, sb, pos;
	logic [19:0]   old_len, diff;
	logic [46:0]   qprod;
	logic [15:0]   new_temp;
	logic [TAW-1:0] tour_base, tour_waddr, tour_raddr;
	logic [DAW-1:0] dist_waddr, dist_raddr;
	logic [3:0]    tour_wdata;
	logic          tour_we;

	assign slot_ok = 32'(item_q.member) < POPULATION;
	assign a_ok    = 32'(item_q.index_a) < CITIES;
	assign b_ok    = 32'(item_q.index_b) < CITIES;
	assign mi      = item_q.member[LW-1:0];
	assign old_len = len_q[mi];
	assign diff    = sum_q - old_len;

	// evaluation walks the tour unswapped
	assign sa  = (item_q.operation == OP_PROPOSE) ? item_q.index_a : 4'd0;
	assign sb  = (item_q.operation == OP_PROPOSE) ? item_q.index_b : 4'd0;
	assign pos = (4'(cnt_q) == sa) ? sb : ((4'(cnt_q) == sb) ? sa : 4'(cnt_q));

	assign tour_base  = TAW'(TAW'(item_q.member) * TAW'(CITIES));
	assign tour_raddr = TAW'(tour_base + TAW'(pos));
	assign dist_waddr = DAW'(DAW'(item_q.index_a) * DAW'(CITIES) + DAW'(item_q.index_b));
	assign dist_raddr = DAW'(DAW'(tour_q[0]) * DAW'(CITIES) + DAW'(tour_q[1]));

	always_comb begin
		tour_we    = cmd.tour_load_wr || cmd.wr_a || cmd.wr_b;
		tour_waddr = TAW'(tour_base + TAW'(item_q.index_a));
		tour_wdata = item_q.city;
		if (cmd.wr_a) begin
			tour_wdata = ca_q;
		end else if (cmd.wr_b) begin
			tour_waddr = TAW'(tour_base + TAW'(item_q.index_b));
			tour_wdata = cb_q;
		end
	end

	assign qprod    = 47'(gprod_q) * 47'(RECIP_100);
	assign new_temp = quot_q[16] ? 16'hFFFF : quot_q[15:0];

	always_comb begin
		sts.op         = item_q.operation;
		sts.slot_ok    = slot_ok;
		sts.dist_ok    = a_ok && b_ok;
		sts.tour_ok    = slot_ok && a_ok;
		sts.swap_ok    = slot_ok && a_ok && b_ok && item_q.index_a != 4'd0 &&
		                 item_q.index_b != 4'd0 && item_q.index_a != item_q.index_b;
		sts.running    = !fin_q && temp_q > stop_q && gen_q <= limit_q;
		sts.cnt_last   = 32'(cnt_q) == CITIES - 1;
		sts.accept     = (sum_q <= old_len) || ({4'd0, diff, 8'd0} < prod_q);
		sts.gen_finish = (gen_q >= limit_q) || (new_temp <= stop_q);
	end

	assign rsp_data = out_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.dist_wr)
			dist_mem[dist_waddr] <= item_q.distance;
		if (cmd.dist_rd)
			dist_rd_q <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (tour_we)
			tour_mem[tour_waddr] <= tour_wdata;
		if (cmd.tour_rd)
			tour_rd_q <= tour_mem[tour_raddr];
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.latch)
			item_q <= req_data;
		if (cmd.set_st)
			status_q <= cmd.st;
		if (cmd.len_wr)
			len_q[mi] <= sum_q;
		if (cmd.tour_start) begin
			cnt_q <= '0;
			sum_q <= '0;
		end
		if (cmd.tour_cap) begin
			for (int j = 0; j < CITIES - 1; j++)
				tour_q[j] <= tour_q[j + 1];
			tour_q[CITIES-1] <= tour_rd_q;
			// position a holds the city now read from b, and the reverse
			if (4'(cnt_q) == item_q.index_a) ca_q <= tour_rd_q;
			if (4'(cnt_q) == item_q.index_b) cb_q <= tour_rd_q;
			cnt_q <= sts.cnt_last ? '0 : CW'(cnt_q + 1'b1);
		end
		if (cmd.dist_rd) begin
			for (int j = 0; j < CITIES - 1; j++)
				tour_q[j] <= tour_q[j + 1];
			tour_q[CITIES-1] <= tour_q[0];
			leg_ok_q <= (32'(tour_q[0]) < CITIES) && (32'(tour_q[1]) < CITIES);
		end
		if (cmd.dist_acc) begin
			if (leg_ok_q)
				sum_q <= sum_q + 20'(dist_rd_q);
			cnt_q <= sts.cnt_last ? '0 : CW'(cnt_q + 1'b1);
		end
		if (cmd.mul)
			prod_q <= 32'(ratio_q) * 32'(temp_q);
		if (cmd.gen_mul)
			gprod_q <= 23'(temp_q) * 23'(cool_q);
		if (cmd.gen_div)
			quot_q <= qprod[RECIP_SHIFT+16:RECIP_SHIFT];
		if (cmd.out_load) begin
			out_q.status              <= status_q;
			out_q.tour_length         <= (slot_ok && (item_q.operation == OP_LOAD_TOUR ||
			                             item_q.operation == OP_EVAL ||
			                             item_q.operation == OP_PROPOSE)) ? old_len : 20'd0;
			out_q.current_temperature <= temp_q;
			out_q.generation          <= gen_q;
		end
	end

	// control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q  <= STOP_TEMP_RST;
			cool_q  <= COOL_PCT_RST;
			ratio_q <= ACC_RATIO_RST;
			limit_q <= GEN_LIMIT_RST;
			temp_q  <= START_TEMP_RST;
			gen_q   <= GEN_RST;
			fin_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_TEMP: temp_q <= cfg_data;
					REG_STOP_TEMP: stop_q  <= cfg_data;
					REG_COOL_PCT:  cool_q  <= cfg_data[6:0];
					REG_ACC_RATIO: ratio_q <= cfg_data;
					REG_GEN_LIMIT: limit_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.gen_upd) begin
				temp_q <= new_temp;
				if (gen_q != GEN_MAX)
					gen_q <= gen_q + 5'd1;
			end
			if (cmd.set_fin)
				fin_q <= 1'b1;
		end
	end

endmodule

[rtl/core/tour_swap_annealing_engine_unit.sv]
// Sequence: loads and status-only words go from dispatch to reply; evaluate and
// propose walk the tour and sum the legs, and an accepted swap then writes both
// positions; end of generation cools the temperature. Throughput: one word at a
// time; the tour walk reads one tour and one distance memory word per position.
// Reset: state machine, temperature, generation count, finished flag and config
// registers return to defaults; distance, tour and length stores stay unset.
// ----------------------------------------------------------------------------
// tour_swap_annealing_engine_unit
// Simulated annealing engine for closed tours with two-position swap moves.
// ----------------------------------------------------------------------------
module tour_swap_annealing_engine_unit #(
	parameter int CITIES     = tsae_pkg::CITIES_DEF,
	parameter int POPULATION = tsae_pkg::POPULATION_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tsae_req_if.sink   req,
	tsae_rsp_if.source rsp,
	tsae_cfg_if.sink   cfg
);
	import tsae_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	tsae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsae_datapath #(
		.CITIES     (CITIES),
		.POPULATION (POPULATION)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_data  (rsp.data)
	);

endmodule

[rtl/core/tsae_checker.sv]
// ----------------------------------------------------------------------------
// tsae_checker
// Port-level checks of the annealing engine, bound to the top level.
// ----------------------------------------------------------------------------
module tsae_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tsae_pkg::rsp_t rsp_data
);
	import tsae_pkg::*;

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// one word in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// generation count starts at one and saturates, never zero
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.generation != 5'd0)
		else $error("generation reported as zero");

endmodule

bind tour_swap_annealing_engine_unit tsae_checker u_tsae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
